FILE: design/fpbs_pkg.sv
// Shared types, constants and fixed-point helpers for the falling particle step.
// Used by fpbs_motion, fpbs_bounce and falling_particle_bounce_step.
// Depends on nothing.
package fpbs_pkg;

    localparam int FRAC_BITS = 16;               // fraction bits of every fixed-point value
    localparam int WORD_W    = 32;               // positions, velocities, gravity, ground
    localparam int AGE_W     = 20;               // age and lifetime
    localparam int FRAC_W    = 16;               // time step and friction factors
    localparam int HALF_W    = 31;               // half size and stop speed
    localparam int PROD_W    = WORD_W + 1 + FRAC_W + 1;  // 33 x 17 signed product
    localparam int WIDE_W    = PROD_W + 1;       // sums before saturation
    localparam int CFG_IDX_W = 3;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_GRAVITY   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DAMPING   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRICTION  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REST_FRIC = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GROUND    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_SIZE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LIFE  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_STOP      = 3'd7;

    // reset values
    localparam logic signed [WORD_W-1:0] GRAVITY_RST   = -32'sd1179648;
    localparam logic [FRAC_W-1:0]        DAMPING_RST   = 16'd22938;
    localparam logic [FRAC_W-1:0]        FRICTION_RST  = 16'd49152;
    localparam logic [FRAC_W-1:0]        REST_FRIC_RST = 16'd55706;
    localparam logic signed [WORD_W-1:0] GROUND_RST    = 32'sd0;
    localparam logic [HALF_W-1:0]        HALF_SIZE_RST = 31'd8192;
    localparam logic [AGE_W-1:0]         MAX_LIFE_RST  = 20'd262144;
    localparam logic [HALF_W-1:0]        STOP_RST      = 31'd65536;

    typedef struct packed {
        logic signed [WORD_W-1:0] pos_x;
        logic signed [WORD_W-1:0] pos_y;
        logic signed [WORD_W-1:0] pos_z;
        logic signed [WORD_W-1:0] vel_x;
        logic signed [WORD_W-1:0] vel_y;
        logic signed [WORD_W-1:0] vel_z;
        logic [AGE_W-1:0]         age;
        logic [FRAC_W-1:0]        time_step;
    } item_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] new_pos_x;
        logic signed [WORD_W-1:0] new_pos_y;
        logic signed [WORD_W-1:0] new_pos_z;
        logic signed [WORD_W-1:0] new_vel_x;
        logic signed [WORD_W-1:0] new_vel_y;
        logic signed [WORD_W-1:0] new_vel_z;
        logic [AGE_W-1:0]         new_age;
        logic                     expired;
    } result_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] gravity_accel;
        logic [FRAC_W-1:0]        bounce_damping;
        logic [FRAC_W-1:0]        bounce_friction;
        logic [FRAC_W-1:0]        rest_friction;
        logic signed [WORD_W-1:0] ground_level;
        logic [HALF_W-1:0]        half_size;
        logic [AGE_W-1:0]         life_limit;
        logic [HALF_W-1:0]        stop_speed;
    } cfg_t;

    // particle state as it travels down the pipeline; age holds the updated age
    typedef struct packed {
        logic  valid;
        item_t item;
        logic  dead;
        logic  hit;
    } stage_t;

    // signed 33-bit value times unsigned 16-bit fraction, exact
    function automatic logic signed [PROD_W-1:0] mul_q(logic signed [WORD_W:0] v,
                                                       logic [FRAC_W-1:0] k);
        logic signed [PROD_W-1:0] a;
        logic signed [PROD_W-1:0] b;
        a = {{(PROD_W-WORD_W-1){v[WORD_W]}}, v};
        b = {{(PROD_W-FRAC_W){1'b0}}, k};
        return a * b;
    endfunction

    // arithmetic shift right by the fraction width, rounding toward minus infinity
    function automatic logic signed [WIDE_W-1:0] asr_q(logic signed [PROD_W-1:0] p);
        logic signed [WIDE_W-1:0] w;
        w = {p[PROD_W-1], p};
        return w >>> FRAC_BITS;
    endfunction

    function automatic logic signed [WIDE_W-1:0] sext(logic signed [WORD_W-1:0] v);
        return {{(WIDE_W-WORD_W){v[WORD_W-1]}}, v};
    endfunction

    function automatic logic signed [WORD_W-1:0] sat32(logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = sext({1'b0, {(WORD_W-1){1'b1}}});
        lo = sext({1'b1, {(WORD_W-1){1'b0}}});
        if (v > hi)
        begin
            return hi[WORD_W-1:0];
        end
        else if (v < lo)
        begin
            return lo[WORD_W-1:0];
        end
        return v[WORD_W-1:0];
    endfunction

endpackage

FILE: design/falling_particle_bounce_step.sv
// Top level of the falling particle step: configuration registers and the
// eight-stage update pipeline. Depends on fpbs_pkg, fpbs_motion, fpbs_bounce.
//
//   channel   | direction | handshake                | word
//   ----------+-----------+--------------------------+------------------------
//   item      | in        | start high, busy low     | fpbs_pkg::item_t
//   result    | out       | done high for one cycle  | fpbs_pkg::result_t
//   config    | in        | cfg_wr high              | cfg_addr, cfg_data
//
// One word enters per clock: busy never rises, so start may be held high
// every cycle. The result word sits on result with done high after it has
// passed stages s1 to s4, b1 to b3 and the output register; the depth is set
// by the four multiply stages, each followed by its own add-and-saturate stage.
// The receiver cannot stall, so the pipeline never holds. Reset (rst_n low)
// clears the pipeline registers and loads the configuration reset values;
// results still in flight are dropped.
module falling_particle_bounce_step
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  fpbs_pkg::item_t                     item,
    output logic                                done,
    output fpbs_pkg::result_t                   result,
    input  logic                                cfg_wr,
    input  logic [fpbs_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [fpbs_pkg::WORD_W-1:0]         cfg_data
);

    fpbs_pkg::cfg_t     cfg_reg;
    fpbs_pkg::cfg_t     cfg_next;
    fpbs_pkg::stage_t   motion;

    // Decode a register write; drop data bits above the register width.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            case (cfg_addr)
                fpbs_pkg::REG_GRAVITY:   cfg_next.gravity_accel   = cfg_data;
                fpbs_pkg::REG_DAMPING:   cfg_next.bounce_damping  =
                    cfg_data[fpbs_pkg::FRAC_W-1:0];
                fpbs_pkg::REG_FRICTION:  cfg_next.bounce_friction =
                    cfg_data[fpbs_pkg::FRAC_W-1:0];
                fpbs_pkg::REG_REST_FRIC: cfg_next.rest_friction   =
                    cfg_data[fpbs_pkg::FRAC_W-1:0];
                fpbs_pkg::REG_GROUND:    cfg_next.ground_level    = cfg_data;
                fpbs_pkg::REG_HALF_SIZE: cfg_next.half_size       =
                    cfg_data[fpbs_pkg::HALF_W-1:0];
                fpbs_pkg::REG_MAX_LIFE:  cfg_next.life_limit      =
                    cfg_data[fpbs_pkg::AGE_W-1:0];
                fpbs_pkg::REG_STOP:      cfg_next.stop_speed      =
                    cfg_data[fpbs_pkg::HALF_W-1:0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gravity_accel   <= fpbs_pkg::GRAVITY_RST;
            cfg_reg.bounce_damping  <= fpbs_pkg::DAMPING_RST;
            cfg_reg.bounce_friction <= fpbs_pkg::FRICTION_RST;
            cfg_reg.rest_friction   <= fpbs_pkg::REST_FRIC_RST;
            cfg_reg.ground_level    <= fpbs_pkg::GROUND_RST;
            cfg_reg.half_size       <= fpbs_pkg::HALF_SIZE_RST;
            cfg_reg.life_limit      <= fpbs_pkg::MAX_LIFE_RST;
            cfg_reg.stop_speed      <= fpbs_pkg::STOP_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Fully pipelined: accept a word on every cycle.
    assign busy = 1'b0;

    // Stages one to four: age, gravity, move, floor test.
    fpbs_motion u_motion
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start & ~busy),
        .item  (item),
        .cfg   (cfg_reg),
        .stage (motion)
    );

    // Stages five to eight: bounce, rest test, output register.
    fpbs_bounce u_bounce
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .stage  (motion),
        .cfg    (cfg_reg),
        .done   (done),
        .result (result)
    );

`ifndef SYNTHESIS
    // Every accepted word comes out with its done strobe.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##8 done)
        else $error("result strobe missing eight cycles after start");

    // No result word without an accepted word ahead of it.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        (!start || busy) |-> ##8 !done)
        else $error("result strobe without an accepted word");

    // An expired word carries an age beyond the lifetime limit.
    a_expired_age: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.expired) |-> (result.new_age > cfg_reg.life_limit))
        else $error("expired flag with age within lifetime");

    // A live word never carries an age past the lifetime limit.
    a_live_age: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.expired) |-> (result.new_age <= cfg_reg.life_limit))
        else $error("live word with age beyond lifetime");
`endif

endmodule

FILE: design/fpbs_motion.sv
// Free flight part of the particle step: age, expiry, gravity and Euler move,
// then the floor test. Four register stages.
// Depends on fpbs_pkg.
module fpbs_motion
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  fpbs_pkg::item_t       item,
    input  fpbs_pkg::cfg_t        cfg,
    output fpbs_pkg::stage_t      stage
);

    // stage 1: age, expiry and the three independent products
    fpbs_pkg::stage_t                          s1_reg;
    fpbs_pkg::stage_t                          s1_next;
    logic signed [fpbs_pkg::PROD_W-1:0]        gdt_reg;
    logic signed [fpbs_pkg::PROD_W-1:0]        vxdt_reg;
    logic signed [fpbs_pkg::PROD_W-1:0]        vzdt_reg;
    logic [fpbs_pkg::AGE_W:0]                  age_sum;

    // stage 2: new vertical velocity and horizontal move
    fpbs_pkg::stage_t                          s2_reg;
    fpbs_pkg::stage_t                          s2_next;

    // stage 3: vertical move product
    fpbs_pkg::stage_t                          s3_reg;
    logic signed [fpbs_pkg::PROD_W-1:0]        vydt_reg;

    // stage 4: height and floor test
    fpbs_pkg::stage_t                          s4_reg;
    fpbs_pkg::stage_t                          s4_next;
    logic signed [fpbs_pkg::WIDE_W-1:0]        bottom;
    logic signed [fpbs_pkg::WIDE_W-1:0]        half_w;

    always_comb
    begin
        s1_next       = '0;
        s1_next.valid = start;
        s1_next.item  = item;
        age_sum       = {1'b0, item.age} + (fpbs_pkg::AGE_W + 1)'(item.time_step);
        if (age_sum[fpbs_pkg::AGE_W])
        begin
            s1_next.item.age = '1;
        end
        else
        begin
            s1_next.item.age = age_sum[fpbs_pkg::AGE_W-1:0];
        end
        s1_next.dead = s1_next.item.age > cfg.life_limit;
    end

    always_comb
    begin
        s2_next = s1_reg;
        if (!s1_reg.dead)
        begin
            s2_next.item.vel_y = fpbs_pkg::sat32(fpbs_pkg::sext(s1_reg.item.vel_y)
                                                 + fpbs_pkg::asr_q(gdt_reg));
            s2_next.item.pos_x = fpbs_pkg::sat32(fpbs_pkg::sext(s1_reg.item.pos_x)
                                                 + fpbs_pkg::asr_q(vxdt_reg));
            s2_next.item.pos_z = fpbs_pkg::sat32(fpbs_pkg::sext(s1_reg.item.pos_z)
                                                 + fpbs_pkg::asr_q(vzdt_reg));
        end
    end

    always_comb
    begin
        s4_next = s3_reg;
        half_w  = $signed({{(fpbs_pkg::WIDE_W-fpbs_pkg::HALF_W){1'b0}}, cfg.half_size});
        if (!s3_reg.dead)
        begin
            s4_next.item.pos_y = fpbs_pkg::sat32(fpbs_pkg::sext(s3_reg.item.pos_y)
                                                 + fpbs_pkg::asr_q(vydt_reg));
        end
        bottom      = fpbs_pkg::sext(s4_next.item.pos_y) - half_w;
        s4_next.hit = !s3_reg.dead && (bottom < fpbs_pkg::sext(cfg.ground_level));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
            s2_reg <= '0;
            s3_reg <= '0;
            s4_reg <= '0;
        end
        else
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s2_reg;
            s4_reg <= s4_next;
        end
    end

    always_ff @(posedge clk)
    begin
        gdt_reg     <= fpbs_pkg::mul_q({cfg.gravity_accel[fpbs_pkg::WORD_W-1],
                                        cfg.gravity_accel}, item.time_step);
        vxdt_reg    <= fpbs_pkg::mul_q({item.vel_x[fpbs_pkg::WORD_W-1], item.vel_x},
                                       item.time_step);
        vzdt_reg    <= fpbs_pkg::mul_q({item.vel_z[fpbs_pkg::WORD_W-1], item.vel_z},
                                       item.time_step);
        vydt_reg    <= fpbs_pkg::mul_q({s2_reg.item.vel_y[fpbs_pkg::WORD_W-1],
                                        s2_reg.item.vel_y}, s2_reg.item.time_step);
    end

    assign stage = s4_reg;

endmodule

FILE: design/fpbs_bounce.sv
// Floor response part of the particle step: put back on the floor, damp and
// reverse, friction, then the rest test and rest friction. Four register stages.
// Depends on fpbs_pkg.
module fpbs_bounce
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  fpbs_pkg::stage_t      stage,
    input  fpbs_pkg::cfg_t        cfg,
    output logic                  done,
    output fpbs_pkg::result_t     result
);

    // stage 1: floor height and bounce products
    fpbs_pkg::stage_t                      b1_reg;
    fpbs_pkg::stage_t                      b1_next;
    logic signed [fpbs_pkg::PROD_W-1:0]    pvy_reg;
    logic signed [fpbs_pkg::PROD_W-1:0]    pvx_reg;
    logic signed [fpbs_pkg::PROD_W-1:0]    pvz_reg;
    logic signed [fpbs_pkg::WORD_W:0]      neg_vy;
    logic signed [fpbs_pkg::WIDE_W-1:0]    half_w;

    // stage 2: bounced velocities and rest test
    fpbs_pkg::stage_t                      b2_reg;
    fpbs_pkg::stage_t                      b2_next;
    logic                                  rest_reg;
    logic                                  rest_next;
    logic [fpbs_pkg::WORD_W:0]             mag;

    // stage 3: rest friction products
    fpbs_pkg::stage_t                      b3_reg;
    logic                                  rest3_reg;
    logic signed [fpbs_pkg::PROD_W-1:0]    rvx_reg;
    logic signed [fpbs_pkg::PROD_W-1:0]    rvz_reg;

    // stage 4: output word
    fpbs_pkg::result_t                     result_reg;
    fpbs_pkg::result_t                     result_next;
    logic                                  done_reg;

    always_comb
    begin
        b1_next = stage;
        neg_vy  = -{stage.item.vel_y[fpbs_pkg::WORD_W-1], stage.item.vel_y};
        half_w  = $signed({{(fpbs_pkg::WIDE_W-fpbs_pkg::HALF_W){1'b0}}, cfg.half_size});
        if (stage.hit)
        begin
            b1_next.item.pos_y = fpbs_pkg::sat32(fpbs_pkg::sext(cfg.ground_level) + half_w);
        end
    end

    always_comb
    begin
        b2_next = b1_reg;
        if (b1_reg.hit)
        begin
            b2_next.item.vel_y = fpbs_pkg::sat32(fpbs_pkg::asr_q(pvy_reg));
            b2_next.item.vel_x = fpbs_pkg::sat32(fpbs_pkg::asr_q(pvx_reg));
            b2_next.item.vel_z = fpbs_pkg::sat32(fpbs_pkg::asr_q(pvz_reg));
        end
        if (b2_next.item.vel_y[fpbs_pkg::WORD_W-1])
        begin
            mag = -{1'b1, b2_next.item.vel_y};
        end
        else
        begin
            mag = {1'b0, b2_next.item.vel_y};
        end
        rest_next = b1_reg.hit && (mag < {2'b00, cfg.stop_speed});
    end

    always_comb
    begin
        result_next.new_pos_x = b3_reg.item.pos_x;
        result_next.new_pos_y = b3_reg.item.pos_y;
        result_next.new_pos_z = b3_reg.item.pos_z;
        result_next.new_vel_x = b3_reg.item.vel_x;
        result_next.new_vel_y = b3_reg.item.vel_y;
        result_next.new_vel_z = b3_reg.item.vel_z;
        result_next.new_age   = b3_reg.item.age;
        result_next.expired   = b3_reg.dead;
        if (rest3_reg)
        begin
            result_next.new_vel_y = '0;
            result_next.new_vel_x = fpbs_pkg::sat32(fpbs_pkg::asr_q(rvx_reg));
            result_next.new_vel_z = fpbs_pkg::sat32(fpbs_pkg::asr_q(rvz_reg));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_reg   <= '0;
            b2_reg   <= '0;
            b3_reg   <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            b1_reg   <= b1_next;
            b2_reg   <= b2_next;
            b3_reg   <= b2_reg;
            done_reg <= b3_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        pvy_reg     <= fpbs_pkg::mul_q(neg_vy, cfg.bounce_damping);
        pvx_reg     <= fpbs_pkg::mul_q({stage.item.vel_x[fpbs_pkg::WORD_W-1],
                                        stage.item.vel_x}, cfg.bounce_friction);
        pvz_reg     <= fpbs_pkg::mul_q({stage.item.vel_z[fpbs_pkg::WORD_W-1],
                                        stage.item.vel_z}, cfg.bounce_friction);

        rest_reg    <= rest_next;

        rest3_reg   <= rest_reg;
        rvx_reg     <= fpbs_pkg::mul_q({b2_reg.item.vel_x[fpbs_pkg::WORD_W-1],
                                        b2_reg.item.vel_x}, cfg.rest_friction);
        rvz_reg     <= fpbs_pkg::mul_q({b2_reg.item.vel_z[fpbs_pkg::WORD_W-1],
                                        b2_reg.item.vel_z}, cfg.rest_friction);

        result_reg  <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

FILE: dv/testbench.sv
// Self-checking bench for falling_particle_bounce_step: directed particle words, then random
// words under several register settings, each result checked against a local step predictor.
// Depends on fpbs_pkg and the falling_particle_bounce_step RTL only.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import fpbs_pkg::*;

    localparam int     LATENCY          = 8;     // start edge to done strobe, the depth of the RTL pipeline
    localparam int     STALL_LIMIT      = 600;   // quiet cycles before giving up
    localparam int     RANDOM_PER_PHASE = 175;
    localparam int     PHASES           = 8;
    localparam longint WORD_MAX         = 64'sd2147483647;
    localparam longint WORD_MIN         = -64'sd2147483648;
    localparam longint AGE_MAX          = 64'sd1048575;

    // one row of the directed stimulus; want only counts where known is set
    typedef struct packed {
        item_t   word;
        logic    known;
        result_t want;
    } stim_row_t;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    item_t   item;
    logic    done;
    result_t result;
    logic    cfg_wr;
    logic [CFG_IDX_W-1:0] cfg_addr;
    logic [WORD_W-1:0]    cfg_data;

    cfg_t        regs;              // shadow of the block's registers
    result_t     pending[$];        // predicted words still to come, oldest first
    stim_row_t   stim_rows[$];
    int unsigned fault_count = 0;
    int unsigned words_seen  = 0;
    int unsigned quiet_cycles = 0;
    int unsigned burst_left  = 0;

    falling_particle_bounce_step u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .item     (item),
        .done     (done),
        .result   (result),
        .cfg_wr   (cfg_wr),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Fixed-point helpers for the predictor. Everything is carried in 64-bit
    // signed arithmetic, which holds every product and sum exactly.
    // ------------------------------------------------------------------
    function automatic longint wide(logic signed [WORD_W-1:0] v);
        return v;
    endfunction

    function automatic longint clamp_word(longint v);
        if (v > WORD_MAX)
        begin
            return WORD_MAX;
        end
        if (v < WORD_MIN)
        begin
            return WORD_MIN;
        end
        return v;
    endfunction

    // product shifted down by the fraction width; >>> floors toward minus infinity
    function automatic longint frac_mul(longint v, longint k);
        return (v * k) >>> FRAC_BITS;
    endfunction

    // One Euler step with the floor bounce, under register settings c.
    function automatic result_t step_particle(item_t w, cfg_t c);
        longint  px, py, pz, vx, vy, vz;
        longint  dt, nage, gnd, hs, mag;
        logic    dead;
        result_t r;
        px   = wide(w.pos_x);
        py   = wide(w.pos_y);
        pz   = wide(w.pos_z);
        vx   = wide(w.vel_x);
        vy   = wide(w.vel_y);
        vz   = wide(w.vel_z);
        dt   = w.time_step;
        nage = longint'(w.age) + dt;
        if (nage > AGE_MAX)
        begin
            nage = AGE_MAX;
        end
        dead = nage > longint'(c.life_limit);
        if (!dead)
        begin
            gnd = wide(c.ground_level);
            hs  = c.half_size;
            // gravity first, so the move already uses the new vertical speed
            vy = clamp_word(vy + frac_mul(wide(c.gravity_accel), dt));
            px = clamp_word(px + frac_mul(vx, dt));
            py = clamp_word(py + frac_mul(vy, dt));
            pz = clamp_word(pz + frac_mul(vz, dt));
            // bottom face below the floor: the test itself is exact, no saturation
            if (py - hs < gnd)
            begin
                py  = clamp_word(gnd + hs);
                vy  = clamp_word(frac_mul(-vy, c.bounce_damping));
                vx  = clamp_word(frac_mul(vx, c.bounce_friction));
                vz  = clamp_word(frac_mul(vz, c.bounce_friction));
                mag = (vy < 0) ? -vy : vy;
                if (mag < longint'(c.stop_speed))
                begin
                    vy = 0;
                    vx = clamp_word(frac_mul(vx, c.rest_friction));
                    vz = clamp_word(frac_mul(vz, c.rest_friction));
                end
            end
        end
        r.new_pos_x = px[WORD_W-1:0];
        r.new_pos_y = py[WORD_W-1:0];
        r.new_pos_z = pz[WORD_W-1:0];
        r.new_vel_x = vx[WORD_W-1:0];
        r.new_vel_y = vy[WORD_W-1:0];
        r.new_vel_z = vz[WORD_W-1:0];
        r.new_age   = nage[AGE_W-1:0];
        r.expired   = dead;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Word builders for the directed table
    // ------------------------------------------------------------------
    function automatic item_t particle(logic [31:0] px, py, pz, vx, vy, vz,
                                       logic [AGE_W-1:0] age, logic [FRAC_W-1:0] dt);
        item_t w;
        w.pos_x     = px;
        w.pos_y     = py;
        w.pos_z     = pz;
        w.vel_x     = vx;
        w.vel_y     = vy;
        w.vel_z     = vz;
        w.age       = age;
        w.time_step = dt;
        return w;
    endfunction

    function automatic result_t outcome(logic [31:0] px, py, pz, vx, vy, vz,
                                        logic [AGE_W-1:0] age, logic gone);
        result_t r;
        r.new_pos_x = px;
        r.new_pos_y = py;
        r.new_pos_z = pz;
        r.new_vel_x = vx;
        r.new_vel_y = vy;
        r.new_vel_z = vz;
        r.new_age   = age;
        r.expired   = gone;
        return r;
    endfunction

    function automatic void add_row(item_t w, logic known, result_t want);
        stim_row_t s;
        s.word  = w;
        s.known = known;
        s.want  = want;
        stim_rows.insert(stim_rows.size(), s);
    endfunction

    // ------------------------------------------------------------------
    // Random word generation
    // ------------------------------------------------------------------
    // signed value whose magnitude is spread evenly over bit lengths up to hi_bits
    function automatic longint spread(int unsigned hi_bits);
        int unsigned b;
        longint      m;
        b = $urandom_range(0, hi_bits);
        m = longint'($urandom) & ((longint'(1) << b) - 1);
        return ($urandom_range(0, 1) != 0) ? -m : m;
    endfunction

    // Mostly particles near the floor so that the bounce and the rest paths get
    // real traffic; the rest are airborne, on the edge of their lifetime, or raw bits.
    function automatic item_t draw_particle();
        item_t       w;
        int unsigned kind;
        longint      rest_h, ml, dt, py, age;
        kind        = $urandom_range(0, 99);
        w.pos_x     = $urandom;
        w.pos_y     = $urandom;
        w.pos_z     = $urandom;
        w.vel_x     = $urandom;
        w.vel_y     = $urandom;
        w.vel_z     = $urandom;
        w.age       = AGE_W'($urandom);
        w.time_step = FRAC_W'($urandom);
        if (kind < 15)
        begin
            return w;
        end
        rest_h = wide(regs.ground_level) + longint'(regs.half_size);
        ml     = regs.life_limit;
        if ($urandom_range(0, 7) == 0)
        begin
            dt = 0;
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            dt = $urandom_range(0, 65535);
        end
        else
        begin
            dt = $urandom_range(1, 6554);
        end
        w.time_step = dt[FRAC_W-1:0];
        if (kind < 85 && ml >= dt)
        begin
            age   = $urandom_range(0, 32'(ml - dt));
            w.age = age[AGE_W-1:0];
        end
        if (kind < 70)
        begin
            py      = clamp_word(rest_h + spread(20));
            w.vel_x = 32'(spread(22));
            w.vel_y = 32'(spread(23));
            w.vel_z = 32'(spread(22));
        end
        else if (kind < 85)
        begin
            py      = clamp_word(rest_h + longint'($urandom_range(32'h1_0000, 32'h1000_0000)));
            w.vel_y = 32'(spread(23));
        end
        else
        begin
            // straddle the lifetime limit by one unit either way
            age = ml - dt + longint'($urandom_range(0, 2)) - 1;
            age = (age < 0) ? 0 : ((age > AGE_MAX) ? AGE_MAX : age);
            w.age = age[AGE_W-1:0];
            py    = clamp_word(rest_h + spread(20));
        end
        w.pos_y = py[WORD_W-1:0];
        return w;
    endfunction

    // sender gap per word: mostly a random gap, now and then a burst with no gaps
    function automatic int unsigned draw_gap();
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0)
        begin
            burst_left = $urandom_range(10, 60);
        end
        return $urandom_range(0, 17);
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic flag_fault(string what);
        $display("%0t mismatch: %s", $realtime, what);
        fault_count++;
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
        begin
            flag_fault($sformatf("word %0d %s got %h want %h", words_seen, name, got, want));
        end
    endtask

    task automatic compare_result(result_t got, result_t want);
        check_field("new_pos_x", got.new_pos_x, want.new_pos_x);
        check_field("new_pos_y", got.new_pos_y, want.new_pos_y);
        check_field("new_pos_z", got.new_pos_z, want.new_pos_z);
        check_field("new_vel_x", got.new_vel_x, want.new_vel_x);
        check_field("new_vel_y", got.new_vel_y, want.new_vel_y);
        check_field("new_vel_z", got.new_vel_z, want.new_vel_z);
        check_field("new_age", 32'(got.new_age), 32'(want.new_age));
        check_field("expired", 32'(got.expired), 32'(want.expired));
    endtask

    // Sample the result port on the rising edge; the block cannot be held off,
    // so every strobe is a word that must match the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
        begin
            if (pending.size() == 0)
            begin
                flag_fault("result word with nothing expected");
            end
            else
            begin
                compare_result(result, pending.pop_front());
            end
            words_seen++;
        end
    end

    // Drop out if nothing moves on either side for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Drivers: every call starts and ends on a falling edge
    // ------------------------------------------------------------------
    // Offer one particle word; predict it unless its outcome is typed in.
    task automatic send_word(item_t w, logic known, result_t want);
        int unsigned gap;
        result_t     predicted;
        gap = draw_gap();
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        predicted = known ? want : step_particle(w, regs);
        start <= 1'b1;
        item  <= w;
        // hold the word until an edge sees busy low
        do
        begin
            @(posedge clk);
        end
        while (busy !== 1'b0);
        pending.insert(pending.size(), predicted);
        @(negedge clk);
    endtask

    // Stop offering words and let the pipeline drain before touching registers.
    task automatic settle();
        start <= 1'b0;
        while (pending.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (LATENCY) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
        cfg_wr   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= data;
        // bits above each register's width are dropped by the block
        case (idx)
            REG_GRAVITY:   regs.gravity_accel   = data;
            REG_DAMPING:   regs.bounce_damping  = data[FRAC_W-1:0];
            REG_FRICTION:  regs.bounce_friction = data[FRAC_W-1:0];
            REG_REST_FRIC: regs.rest_friction   = data[FRAC_W-1:0];
            REG_GROUND:    regs.ground_level    = data;
            REG_HALF_SIZE: regs.half_size       = data[HALF_W-1:0];
            REG_MAX_LIFE:  regs.life_limit      = data[AGE_W-1:0];
            REG_STOP:      regs.stop_speed      = data[HALF_W-1:0];
            default:       ;
        endcase
        @(negedge clk);
    endtask

    task automatic load_settings(logic [31:0] grav, damp, fric, rest, gnd, half, life, stop);
        write_reg(REG_GRAVITY, grav);
        write_reg(REG_DAMPING, damp);
        write_reg(REG_FRICTION, fric);
        write_reg(REG_REST_FRIC, rest);
        write_reg(REG_GROUND, gnd);
        write_reg(REG_HALF_SIZE, half);
        write_reg(REG_MAX_LIFE, life);
        write_reg(REG_STOP, stop);
        cfg_wr <= 1'b0;
    endtask

    // Register settings per phase; phase 0 keeps the reset values.
    task automatic pick_settings(int phase);
        longint g, gnd;
        case (phase)
            1:  // everything at its low end: nothing lives past age zero
                load_settings(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
            2:  // everything at its high end: every live particle hits the floor
                load_settings(32'h7FFF_FFFF, 32'hFFFF, 32'hFFFF, 32'hFFFF,
                              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hF_FFFF, 32'h7FFF_FFFF);
            3:  // floor at the bottom of the range, strongest downward pull
                load_settings(32'h8000_0000, 32'hFFFF, 32'hFFFF, 32'hFFFF,
                              32'h8000_0000, 32'h0, 32'hF_FFFF, 32'h0);
            4, 5:  // raw bits, upper bits beyond each width included
                load_settings($urandom, $urandom, $urandom, $urandom,
                              $urandom, $urandom, $urandom, $urandom);
            6:
            begin
                // plausible scene: modest gravity, floor near zero, small cubes
                g   = -longint'($urandom_range(0, 30 * 65536));
                gnd = longint'($urandom_range(0, 8 * 65536)) - 4 * 65536;
                load_settings(g[31:0], $urandom_range(0, 65535), $urandom_range(0, 65535),
                              $urandom_range(0, 65535), gnd[31:0],
                              $urandom_range(0, 65536), $urandom_range(65536, 20'hF_FFFF),
                              $urandom_range(0, 4 * 65536));
            end
            default:  // back to the reset values, written explicitly
                load_settings(GRAVITY_RST, DAMPING_RST, FRICTION_RST, REST_FRIC_RST,
                              GROUND_RST, HALF_SIZE_RST, MAX_LIFE_RST, STOP_RST);
        endcase
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n    = 1'b0;
        start    = 1'b0;
        item     = '0;
        cfg_wr   = 1'b0;
        cfg_addr = '0;
        cfg_data = '0;

        regs.gravity_accel   = GRAVITY_RST;
        regs.bounce_damping  = DAMPING_RST;
        regs.bounce_friction = FRICTION_RST;
        regs.rest_friction   = REST_FRIC_RST;
        regs.ground_level    = GROUND_RST;
        regs.half_size       = HALF_SIZE_RST;
        regs.life_limit      = MAX_LIFE_RST;
        regs.stop_speed      = STOP_RST;

        // Directed words under the reset settings. Outcomes are typed in where the
        // particle is dead, untouched, or trivially parked on the floor.
        // resting on the floor at zero: lifted by half a cube, all else zero
        add_row(particle(0, 0, 0, 0, 0, 0, 20'd0, 16'd0), 1'b1,
                outcome(0, 32'd8192, 0, 0, 0, 0, 20'd0, 1'b0));
        // age saturates at the top of its range; dead words echo their inputs
        add_row(particle(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                         32'h7FFF_FFFF, 32'h8000_0000, 20'hF_FFFF, 16'hFFFF), 1'b1,
                outcome(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                        32'h7FFF_FFFF, 32'h8000_0000, 20'hF_FFFF, 1'b1));
        // one step past the lifetime limit
        add_row(particle(32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000, 32'h0000_8000,
                         32'hFFFF_8000, 32'h0, 20'd262144, 16'd1), 1'b1,
                outcome(32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000, 32'h0000_8000,
                        32'hFFFF_8000, 32'h0, 20'd262145, 1'b1));
        // exactly at the lifetime limit: still alive
        add_row(particle(32'h0, 32'h0010_0000, 32'h0, 32'h0001_0000, 32'h0, 32'h0,
                         20'd262144, 16'd0), 1'b0, '0);
        // zero step in mid air: nothing moves
        add_row(particle(32'h0001_0000, 32'h000A_0000, 32'hFFFF_0000, 32'h0002_0000,
                         32'h0003_0000, 32'hFFFC_0000, 20'd100, 16'd0), 1'b1,
                outcome(32'h0001_0000, 32'h000A_0000, 32'hFFFF_0000, 32'h0002_0000,
                        32'h0003_0000, 32'hFFFC_0000, 20'd100, 1'b0));
        // bottom exactly on the floor is not below it
        add_row(particle(32'h0, 32'd8192, 32'h0, 32'd5, 32'h0, 32'd7, 20'd0, 16'd0), 1'b1,
                outcome(32'h0, 32'd8192, 32'h0, 32'd5, 32'h0, 32'd7, 20'd0, 1'b0));
        // one unit lower, zero step: the floor test still fires
        add_row(particle(32'h0, 32'd8191, 32'h0, 32'h0003_0000, 32'hFFFE_0000,
                         32'hFFFD_0000, 20'd0, 16'd0), 1'b0, '0);
        // position saturates upward and downward
        add_row(particle(32'h7FFF_FFFF, 32'h4000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                         32'h0, 32'h8000_0000, 20'd0, 16'hFFFF), 1'b0, '0);
        // vertical speed saturates downward, then a fall from the top of the range
        add_row(particle(32'h0, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h8000_0000,
                         32'h0, 20'd0, 16'hFFFF), 1'b0, '0);
        // rising at full speed
        add_row(particle(32'h0, 32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h0,
                         20'd0, 16'hFFFF), 1'b0, '0);
        // hard bounce that keeps going
        add_row(particle(32'h0, 32'h0000_8000, 32'h0, 32'h0003_0000, 32'hFFF6_0000,
                         32'hFFFE_0000, 20'd0, 16'd6554), 1'b0, '0);
        // soft landing that comes to rest
        add_row(particle(32'h0, 32'd8292, 32'h0, 32'h0001_0000, 32'hFFFF_8000,
                         32'hFFFF_0000, 20'd1000, 16'd1092), 1'b0, '0);
        // bounce with horizontal speeds at their extremes
        add_row(particle(32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'hFFEC_0000,
                         32'h8000_0000, 20'd0, 16'd1092), 1'b0, '0);
        // deep below the floor, falling as fast as possible
        add_row(particle(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                         32'h8000_0000, 32'h7FFF_FFFF, 20'd0, 16'hFFFF), 1'b0, '0);
        // all ones in the live range of age
        add_row(particle(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                         32'hFFFF_FFFF, 32'hFFFF_FFFF, 20'd0, 16'hFFFF), 1'b0, '0);

        // hold reset low, then release it away from the rising edge
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (stim_rows[i])
        begin
            send_word(stim_rows[i].word, stim_rows[i].known, stim_rows[i].want);
        end

        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase != 0)
            begin
                settle();
                pick_settings(phase);
            end
            repeat (RANDOM_PER_PHASE)
            begin
                send_word(draw_particle(), 1'b0, '0);
            end
        end

        // drain, then keep waiting past the pipeline depth for strays
        start <= 1'b0;
        while (pending.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (LATENCY + 4) @(posedge clk);
        if (pending.size() != 0)
        begin
            flag_fault("predicted words never arrived");
        end

        if (fault_count == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

FILE: files.f
design/fpbs_pkg.sv
design/fpbs_motion.sv
design/fpbs_bounce.sv
design/falling_particle_bounce_step.sv
dv/testbench.sv
